/* design/gcdl_pkg.sv */
// Package for the gcd/lcm unit: transaction payload types, sequencer states
// and width constants. No dependencies.
package gcdl_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int VALUE_WIDTH       = 62;

  typedef struct packed {
    logic                          mode;
    logic signed [FIELD_WIDTH-1:0] operand_a;
    logic signed [FIELD_WIDTH-1:0] operand_b;
  } op_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   both_zero;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_FIN,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

endpackage

/* design/gcdl_addsub.sv */
// Shared adder/subtractor of the gcd/lcm unit; carry out is the no-borrow
// flag on a subtract. Depends on nothing.
module gcdl_addsub #(
  parameter int AW = 33
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] sum,
  output logic          carry
);

  logic [AW-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{AW{1'b0}}, sub};

endmodule

/* design/gcd_lcm_unit.sv */
// Binary gcd does one shift, subtract or swap a cycle; lcm adds
// OPERAND_WIDTH restoring-division steps and OPERAND_WIDTH shift-add
// multiply steps, plus decision and hand-off. One transaction is in work
// at a time; every subtract and every division and multiply step uses
// the one shared adder. Synchronous active-high reset returns the
// sequencer to idle and drops res_valid. Depends on gcdl_pkg and gcdl_addsub.
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = gcdl_pkg::OPERAND_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_ready,
  input  gcdl_pkg::op_t  op,
  output logic           res_valid,
  input  logic           res_ready,
  output gcdl_pkg::res_t res
);
  import gcdl_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int KW = $clog2(W);

  state_t state, state_next;

  logic            lcm_mode;
  logic [W-1:0]    mag_a, mag_b;
  logic [W-1:0]    x, y, x_next, y_next;
  logic [KW-1:0]   k, k_next;
  logic [W-1:0]    g, g_next;
  logic [W-1:0]    rem, rem_next;
  logic [W-1:0]    q, q_next;
  logic [2*W-1:0]  prod, prod_next;
  logic [KW-1:0]   cnt, cnt_next;
  logic [2*W-1:0]  hold_value, hold_value_next;
  logic            hold_flag, hold_flag_next;

  logic [W-1:0]    a_low, b_low, mag_a_in, mag_b_in;
  logic [W:0]      add_a, add_b, add_sum;
  logic            add_sub, add_carry;
  logic [VALUE_WIDTH+2*W-1:0] value_wide;
  logic            res_load;

  assign a_low    = op.operand_a[W-1:0];
  assign b_low    = op.operand_b[W-1:0];
  assign mag_a_in = a_low[W-1] ? (~a_low + 1'b1) : a_low;
  assign mag_b_in = b_low[W-1] ? (~b_low + 1'b1) : b_low;

  assign op_ready   = (state == S_IDLE);
  assign res_load   = (state == S_DONE) && (!res_valid || res_ready);
  assign value_wide = {{VALUE_WIDTH{1'b0}}, hold_value};

  gcdl_addsub #(.AW(W + 1)) u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  // Operand routing into the shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      S_GCD: begin
        add_a   = {1'b0, x};
        add_b   = {1'b0, y};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = {rem, q[W-1]};
        add_b   = {1'b0, g};
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_a   = {1'b0, prod[2*W-1:W]};
        add_b   = {1'b0, prod[0] ? mag_b : {W{1'b0}}};
        add_sub = 1'b0;
      end
      default: begin
        add_a   = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (op_valid) state_next = S_GCD;
      S_GCD:  if (x == '0 || y == '0) state_next = S_FIN;
      S_FIN: begin
        if (lcm_mode && g != '0 && mag_a != '0 && mag_b != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV:  if (cnt == '0) state_next = S_MUL;
      S_MUL:  if (cnt == '0) state_next = S_DONE;
      S_DONE: if (res_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath next values.
  always_comb begin
    x_next          = x;
    y_next          = y;
    k_next          = k;
    g_next          = g;
    rem_next        = rem;
    q_next          = q;
    prod_next       = prod;
    cnt_next        = cnt;
    hold_value_next = hold_value;
    hold_flag_next  = hold_flag;
    case (state)
      S_IDLE: begin
        x_next = mag_a_in;
        y_next = mag_b_in;
        k_next = '0;
      end
      S_GCD: begin
        // Once one side is zero the other, with the common powers of two
        // restored, is the gcd. Both zero gives zero.
        if (x == '0 || y == '0) begin
          g_next = (x | y) << k;
        end else if (!x[0] && !y[0]) begin
          x_next = x >> 1;
          y_next = y >> 1;
          k_next = k + 1'b1;
        end else if (!x[0]) begin
          x_next = x >> 1;
        end else if (!y[0]) begin
          y_next = y >> 1;
        end else if (add_carry) begin
          x_next = add_sum[W-1:0];
        end else begin
          // x < y: swap so the next subtract is non-negative.
          x_next = y;
          y_next = x;
        end
      end
      S_FIN: begin
        hold_flag_next  = 1'b0;
        hold_value_next = '0;
        if (!lcm_mode) begin
          hold_value_next = {{W{1'b0}}, g};
        end else if (g == '0) begin
          hold_flag_next = 1'b1;
        end else if (mag_a != '0 && mag_b != '0) begin
          rem_next = '0;
          q_next   = mag_a;
          cnt_next = KW'(W - 1);
        end
      end
      S_DIV: begin
        rem_next = add_carry ? add_sum[W-1:0] : add_a[W-1:0];
        q_next   = {q[W-2:0], add_carry};
        if (cnt == '0) begin
          prod_next = {{W{1'b0}}, q_next};
          cnt_next  = KW'(W - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_MUL: begin
        prod_next = {add_sum, prod[W-1:1]};
        if (cnt == '0) begin
          hold_value_next = prod_next;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && op_valid) begin
      lcm_mode <= op.mode;
      mag_a    <= mag_a_in;
      mag_b    <= mag_b_in;
    end
    x          <= x_next;
    y          <= y_next;
    k          <= k_next;
    g          <= g_next;
    rem        <= rem_next;
    q          <= q_next;
    prod       <= prod_next;
    cnt        <= cnt_next;
    hold_value <= hold_value_next;
    hold_flag  <= hold_flag_next;
    if (res_load) begin
      res.value     <= value_wide[VALUE_WIDTH-1:0];
      res.both_zero <= hold_flag;
    end
  end

endmodule

/* design/gcdl_checker.sv */
// Port-level checks for gcd_lcm_unit, attached by the bind at the end.
// Depends on gcdl_pkg.
module gcdl_checker (
  input logic           clk,
  input logic           rst,
  input logic           op_valid,
  input logic           op_ready,
  input gcdl_pkg::op_t  op,
  input logic           res_valid,
  input logic           res_ready,
  input gcdl_pkg::res_t res
);
  import gcdl_pkg::*;

  // A waiting result transaction holds its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // The flag only comes with a zero value.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.both_zero |-> res.value == '0)
    else $error("both_zero set with nonzero value");

  // The unit is busy right after taking a transaction.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("ready right after accept");

  // No result can appear the cycle after a transaction is taken.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !$rose(res_valid))
    else $error("result too early");

endmodule

bind gcd_lcm_unit gcdl_checker u_gcdl_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for gcd_lcm_unit: directed corner cases and random operand pairs,
// each checked against an in-bench gcd/lcm predictor under varying handshake pressure.
// Depends on gcdl_pkg and the gcd_lcm_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import gcdl_pkg::*;

  localparam int OPW           = OPERAND_WIDTH_DEF;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 300;

  localparam logic MODE_GCD = 1'b0;
  localparam logic MODE_LCM = 1'b1;

  localparam logic [FIELD_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [FIELD_WIDTH-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [FIELD_WIDTH-1:0] MINUS_ONE = 32'hffff_ffff;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic op_valid  = 1'b0;
  logic op_ready;
  op_t  op        = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  res_t        expected_results[$];

  gcd_lcm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #2 clk = ~clk;

  // Magnitude of the low OPW bits read as two's complement; the most negative
  // value keeps its full magnitude since the arithmetic is 64 bits wide.
  function automatic logic [63:0] magnitude(logic [FIELD_WIDTH-1:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << OPW) - 64'd1;
    v = 64'(raw) & mask;
    if (v[OPW-1]) v = (~v + 64'd1) & mask;
    return v;
  endfunction

  function automatic res_t gcd_lcm_of(op_t t);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    res_t        e;
    ma = magnitude(t.operand_a);
    mb = magnitude(t.operand_b);
    x = ma;
    y = mb;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    e = '0;
    if (t.mode == MODE_GCD) begin
      e.value = x[VALUE_WIDTH-1:0];
    end else if (x == 0) begin
      e.both_zero = 1'b1;
    end else if (ma != 0 && mb != 0) begin
      e.value = VALUE_WIDTH'((ma / x) * mb);
    end
    return e;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] random_operand();
    logic [FIELD_WIDTH-1:0] v;
    case ($urandom_range(7))
      0: v = $urandom;
      1: v = $urandom_range(255);
      2: v = '0;
      3: v = 32'd1 << $urandom_range(31);
      4: begin
        case ($urandom_range(3))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          default: v = 32'd1;
        endcase
      end
      5: v = $urandom << $urandom_range(24);
      6: v = $urandom_range(1000000);
      default: v = $urandom_range(65535);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Sends one transaction, idling first as the current phase asks, and records
  // its expected result once it is accepted.
  task automatic issue_operands(input logic m, input logic [FIELD_WIDTH-1:0] a,
                                input logic [FIELD_WIDTH-1:0] b);
    op_t item;
    item.mode      = m;
    item.operand_a = a;
    item.operand_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    op       <= item;
    do @(posedge clk); while (!op_ready);
    expected_results.push_back(gcd_lcm_of(item));
  endtask

  task automatic drain_results();
    op_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [FIELD_WIDTH-1:0] pair_a [11];
    logic [FIELD_WIDTH-1:0] pair_b [11];
    pair_a = '{32'd0, 32'd0, 32'd12, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
               MOST_POS, -32'd12, MINUS_ONE, MOST_NEG};
    pair_b = '{32'd0, -32'd7, 32'd0, 32'd0, MOST_NEG, MINUS_ONE, MOST_POS,
               MOST_POS - 32'd1, 32'd18, MINUS_ONE, 32'h4000_0000};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 11; i++) begin
      issue_operands(MODE_GCD, pair_a[i], pair_b[i]);
      issue_operands(MODE_LCM, pair_a[i], pair_b[i]);
    end
    drain_results();
  endtask

  // Random operand pairs; a third of them share a sizable common factor so
  // that gcd results other than small numbers show up often.
  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    logic [FIELD_WIDTH-1:0] a;
    logic [FIELD_WIDTH-1:0] b;
    logic [FIELD_WIDTH-1:0] common;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(2) == 0) begin
        common = $urandom_range(1, 65535);
        a = common * $urandom_range(0, 32767);
        b = common * $urandom_range(0, 32767);
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end else begin
        a = random_operand();
        b = random_operand();
      end
      issue_operands($urandom_range(1) ? MODE_LCM : MODE_GCD, a, b);
    end
    drain_results();
  endtask

  task automatic test_no_idling();
    run_random(440, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(440, 70, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(440, 0, 70);
  endtask

  task automatic test_both_idle();
    run_random(440, 26, 26);
  endtask

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: value=%0d both_zero=%0b",
                   res.value, res.both_zero);
      end else begin
        want = expected_results.pop_front();
        if (res.value !== want.value || res.both_zero !== want.both_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d both_zero=%0b, got value=%0d both_zero=%0b",
                     want.value, want.both_zero, res.value, res.both_zero);
        end
      end
    end
  end

  // The watchdog only counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((op_valid && op_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
